FILE: design/jsue_pkg.sv
// Shared types, constants and helper functions for the JSON \uXXXX to UTF-8 decoder.
// Used by the character lanes, the merge stage and the top level; depends on nothing.
package jsue_pkg;

   // Number of characters carried by one transaction: four escape digits and six lookahead.
   localparam int LaneCount = 10;
   localparam int EscDigits = 4;
   localparam int LookBase  = 4;
   localparam int LowBase   = 6;

   // Availability thresholds.
   localparam logic [3:0] AVAIL_ESCAPE = 4'd4;
   localparam logic [3:0] AVAIL_PAIR   = 4'd10;

   // Consumed character counts.
   localparam logic [3:0] CONSUMED_SINGLE = 4'd4;
   localparam logic [3:0] CONSUMED_PAIR   = 4'd10;

   // Characters of interest.
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] LOWER_BIAS     = 8'h57;
   localparam logic [7:0] UPPER_BIAS     = 8'h37;

   // Surrogate ranges and code point limits.
   localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
   localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
   localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
   localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;
   localparam logic [20:0] REPLACEMENT   = 21'h0FFFD;
   localparam logic [20:0] LIMIT_ONE     = 21'h00080;
   localparam logic [20:0] LIMIT_TWO     = 21'h00800;
   localparam logic [20:0] LIMIT_THREE   = 21'h10000;

   // UTF-8 lead and continuation markers.
   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] CONT_MARK  = 8'h80;
   localparam logic [5:0] CONT_MASK  = 6'h3F;

   // Byte counts.
   localparam logic [2:0] COUNT_ONE   = 3'd1;
   localparam logic [2:0] COUNT_TWO   = 3'd2;
   localparam logic [2:0] COUNT_THREE = 3'd3;
   localparam logic [2:0] COUNT_FOUR  = 3'd4;

   // Classification of one character by a lane.
   typedef struct packed {
      logic       is_hex;
      logic [3:0] nibble;
      logic       is_backslash;
      logic       is_u;
   } char_class_type;

   typedef char_class_type [LaneCount-1:0] lane_bus_type;

   // Result of one four-digit group.
   typedef struct packed {
      logic        ok;
      logic [15:0] value;
   } parse4_type;

   // One result transaction.
   typedef struct packed {
      logic       ok;
      logic [3:0] consumed;
      logic [2:0] byte_count;
      logic [7:0] byte3;
      logic [7:0] byte2;
      logic [7:0] byte1;
      logic [7:0] byte0;
   } result_type;

   // Value of the leading hex digits of a four-character group.
   function automatic parse4_type parse4(input char_class_type d0, input char_class_type d1,
                                         input char_class_type d2, input char_class_type d3);
      parse4_type res;
      res.ok = d0.is_hex;
      if (d0.is_hex && d1.is_hex && d2.is_hex && d3.is_hex) begin
         res.value = {d0.nibble, d1.nibble, d2.nibble, d3.nibble};
      end else if (d0.is_hex && d1.is_hex && d2.is_hex) begin
         res.value = {4'h0, d0.nibble, d1.nibble, d2.nibble};
      end else if (d0.is_hex && d1.is_hex) begin
         res.value = {8'h00, d0.nibble, d1.nibble};
      end else begin
         res.value = {12'h000, d0.nibble};
      end
      return res;
   endfunction

endpackage

FILE: design/jsue_char_lane.sv
// One character lane: classifies a raw byte as a hex digit, a backslash or the letter u.
// Depends on jsue_pkg for the character constants and the lane result type.
module jsue_char_lane (
   input  logic [7:0]               char_in,
   output jsue_pkg::char_class_type class_out
);

   logic [7:0] diff_digit;
   logic [7:0] diff_lower;
   logic [7:0] diff_upper;

   assign diff_digit = char_in - jsue_pkg::CHAR_ZERO;
   assign diff_lower = char_in - jsue_pkg::LOWER_BIAS;
   assign diff_upper = char_in - jsue_pkg::UPPER_BIAS;

   // Hex digit decode over the three accepted ranges.
   always_comb begin
      class_out.is_hex       = 1'b0;
      class_out.nibble       = 4'h0;
      class_out.is_backslash = (char_in == jsue_pkg::CHAR_BACKSLASH);
      class_out.is_u         = (char_in == jsue_pkg::CHAR_U);
      if (char_in >= jsue_pkg::CHAR_ZERO && char_in <= jsue_pkg::CHAR_NINE) begin
         class_out.is_hex = 1'b1;
         class_out.nibble = diff_digit[3:0];
      end else if (char_in >= jsue_pkg::CHAR_LOWER_A && char_in <= jsue_pkg::CHAR_LOWER_F) begin
         class_out.is_hex = 1'b1;
         class_out.nibble = diff_lower[3:0];
      end else if (char_in >= jsue_pkg::CHAR_UPPER_A && char_in <= jsue_pkg::CHAR_UPPER_F) begin
         class_out.is_hex = 1'b1;
         class_out.nibble = diff_upper[3:0];
      end
   end

endmodule

FILE: design/jsue_merge.sv
// Merge stage: combines the lane results into a code point and encodes it as UTF-8.
// Depends on jsue_pkg for types, constants and the four-digit parse function.
module jsue_merge (
   input  jsue_pkg::lane_bus_type lanes,
   input  logic [3:0]             chars_available,
   output jsue_pkg::result_type   result
);

   jsue_pkg::parse4_type high_part;
   jsue_pkg::parse4_type low_part;
   logic                 is_high;
   logic                 is_low;
   logic                 low_in_range;
   logic                 paired;
   logic [20:0]          joined;
   logic [20:0]          code;

   // Leading-digit values of the escape body and of the lookahead escape.
   assign high_part = jsue_pkg::parse4(lanes[0], lanes[1], lanes[2], lanes[3]);
   assign low_part  = jsue_pkg::parse4(lanes[jsue_pkg::LowBase],   lanes[jsue_pkg::LowBase+1],
                                       lanes[jsue_pkg::LowBase+2], lanes[jsue_pkg::LowBase+3]);

   // Surrogate classification and pair detection.
   assign is_high = high_part.value >= jsue_pkg::SURR_HI_FIRST &&
                    high_part.value <= jsue_pkg::SURR_HI_LAST;
   assign is_low  = high_part.value >= jsue_pkg::SURR_LO_FIRST &&
                    high_part.value <= jsue_pkg::SURR_LO_LAST;
   assign low_in_range = low_part.value >= jsue_pkg::SURR_LO_FIRST &&
                         low_part.value <= jsue_pkg::SURR_LO_LAST;
   assign paired = is_high && chars_available >= jsue_pkg::AVAIL_PAIR &&
                   lanes[jsue_pkg::LookBase].is_backslash &&
                   lanes[jsue_pkg::LookBase+1].is_u &&
                   low_part.ok && low_in_range;
   assign joined = jsue_pkg::SUPP_BASE + {1'b0, high_part.value[9:0], low_part.value[9:0]};

   // Code point selection.
   always_comb begin
      if (paired) begin
         code = joined;
      end else if (is_high || is_low) begin
         code = jsue_pkg::REPLACEMENT;
      end else begin
         code = {5'h00, high_part.value};
      end
   end

   // UTF-8 encoding; a failed transaction returns all zeros.
   always_comb begin
      result = '0;
      if (chars_available >= jsue_pkg::AVAIL_ESCAPE && high_part.ok) begin
         result.ok       = 1'b1;
         result.consumed = paired ? jsue_pkg::CONSUMED_PAIR : jsue_pkg::CONSUMED_SINGLE;
         if (code < jsue_pkg::LIMIT_ONE) begin
            result.byte_count = jsue_pkg::COUNT_ONE;
            result.byte0      = code[7:0];
         end else if (code < jsue_pkg::LIMIT_TWO) begin
            result.byte_count = jsue_pkg::COUNT_TWO;
            result.byte0      = jsue_pkg::LEAD_TWO | {3'b000, code[10:6]};
            result.byte1      = jsue_pkg::CONT_MARK | {2'b00, code[5:0] & jsue_pkg::CONT_MASK};
         end else if (code < jsue_pkg::LIMIT_THREE) begin
            result.byte_count = jsue_pkg::COUNT_THREE;
            result.byte0      = jsue_pkg::LEAD_THREE | {4'h0, code[15:12]};
            result.byte1      = jsue_pkg::CONT_MARK | {2'b00, code[11:6] & jsue_pkg::CONT_MASK};
            result.byte2      = jsue_pkg::CONT_MARK | {2'b00, code[5:0] & jsue_pkg::CONT_MASK};
         end else begin
            result.byte_count = jsue_pkg::COUNT_FOUR;
            result.byte0      = jsue_pkg::LEAD_FOUR | {5'h00, code[20:18]};
            result.byte1      = jsue_pkg::CONT_MARK | {2'b00, code[17:12] & jsue_pkg::CONT_MASK};
            result.byte2      = jsue_pkg::CONT_MARK | {2'b00, code[11:6] & jsue_pkg::CONT_MASK};
            result.byte3      = jsue_pkg::CONT_MARK | {2'b00, code[5:0] & jsue_pkg::CONT_MASK};
         end
      end
   end

endmodule

FILE: design/json_unicode_escape_to_utf8_top.sv
// JSON \uXXXX escape to UTF-8 decoder, top level.
// rsp_tvalid rises once the merged result of an accepted input transaction is loaded into
// the output register.
// Throughput: one transaction per cycle while rsp_tready does not hold the output back; ten
// character lanes classify in parallel, a lane register follows, then the merge stage feeds the output register.
// Reset (synchronous, active high) empties both pipeline stages.
// Depends on jsue_pkg, jsue_char_lane and jsue_merge.
module json_unicode_escape_to_utf8_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: hex_char0..3, look0..5 (8 bits each), chars_available (4), zero pad (4).
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: consumed (4), byte_count (3), byte0..byte3 (8 each), zero pad (1).
   output logic [39:0] rsp_tdata,
   // Fields from bit 0: ok (1).
   output logic [0:0]  rsp_tuser
);

   jsue_pkg::lane_bus_type lanes_now;
   jsue_pkg::lane_bus_type lanes_ff;
   logic [3:0]             avail_ff;
   logic                   lane_valid_ff;
   logic                   lane_valid_in;
   logic                   lane_advance;
   jsue_pkg::result_type   merged;
   jsue_pkg::result_type   rsp_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_load;

   // Character lanes, one per byte of the transaction.
   for (genvar g = 0; g < jsue_pkg::LaneCount; g++) begin : g_lane
      jsue_char_lane u_lane (
         .char_in   (req_tdata[8*g +: 8]),
         .class_out (lanes_now[g])
      );
   end

   // Pipeline handshake: each stage moves when the one after it has room.
   assign rsp_load      = !rsp_valid_ff || rsp_tready;
   assign lane_advance  = lane_valid_ff && rsp_load;
   assign req_tready    = !lane_valid_ff || rsp_load;
   assign lane_valid_in = (req_tvalid && req_tready) || (lane_valid_ff && !rsp_load);
   assign rsp_valid_in  = lane_valid_ff || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         lane_valid_ff <= lane_valid_in;
         if (rsp_load) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   // Lane register.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         lanes_ff <= lanes_now;
         avail_ff <= req_tdata[8*jsue_pkg::LaneCount +: 4];
      end
   end

   // Merge of the lane results.
   jsue_merge u_merge (
      .lanes           (lanes_ff),
      .chars_available (avail_ff),
      .result          (merged)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (lane_advance) begin
         rsp_ff <= merged;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.ok;
   assign rsp_tdata  = {1'b0, rsp_ff.byte3, rsp_ff.byte2, rsp_ff.byte1, rsp_ff.byte0,
                        rsp_ff.byte_count, rsp_ff.consumed};

endmodule

FILE: dv/tb_json_unicode_escape_to_utf8_top.sv
// Self-checking testbench for the JSON \uXXXX escape to UTF-8 decoder.
// A directed table and random escapes, surrogate pairs and noise are checked against hand-written
// results or an in-bench decoder model; depends on jsue_pkg and json_unicode_escape_to_utf8_top.
module tb_json_unicode_escape_to_utf8_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIR_ROWS     = 26;
   localparam int RANDOM_ITEMS = 750;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_MAX   = 10;

   localparam jsue_pkg::result_type DECODE_FAIL = '0;

   // One row of the directed table: ten characters, first one in the top byte.
   typedef struct packed {
      logic [79:0]          text;
      logic [3:0]           avail;
      logic                 typed;
      jsue_pkg::result_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   jsue_pkg::result_type pending_utf8 [$];
   int                   bad_results = 0;
   int                   cycle_count = 0;
   logic                 quiet_phase = 1'b0;
   dir_row_type          dir_table [DIR_ROWS];

   json_unicode_escape_to_utf8_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Classify one character: bit 4 says it is a hex digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_nibble(logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= jsue_pkg::CHAR_ZERO && c <= jsue_pkg::CHAR_NINE) begin
         d = c - jsue_pkg::CHAR_ZERO;
      end else if (c >= jsue_pkg::CHAR_LOWER_A && c <= jsue_pkg::CHAR_LOWER_F) begin
         d = c - jsue_pkg::CHAR_LOWER_A + 8'd10;
      end else if (c >= jsue_pkg::CHAR_UPPER_A && c <= jsue_pkg::CHAR_UPPER_F) begin
         d = c - jsue_pkg::CHAR_UPPER_A + 8'd10;
      end else begin
         return 5'b0;
      end
      return {1'b1, d[3:0]};
   endfunction

   // Value of the leading hex digits of four characters, first one in the low byte.
   // Bit 16 is set when the first character is a digit.
   function automatic logic [16:0] lead_value(logic [31:0] grp);
      logic [15:0] v;
      logic [4:0]  d;
      logic        first_ok;
      logic        stopped;
      v        = 16'h0000;
      stopped  = 1'b0;
      d        = hex_nibble(grp[7:0]);
      first_ok = d[4];
      for (int i = 0; i < jsue_pkg::EscDigits; i++) begin
         d = hex_nibble(grp[8*i +: 8]);
         if (!d[4]) stopped = 1'b1;
         if (!stopped) v = {v[11:0], d[3:0]};
      end
      return {first_ok, v};
   endfunction

   // Decode one escape: lanes hold hex_char0..3 and look0..5, lane 0 in the low byte.
   function automatic jsue_pkg::result_type decode_escape(logic [79:0] lanes,
                                                          logic [3:0] avail);
      jsue_pkg::result_type r;
      logic [16:0]          hi;
      logic [16:0]          lo;
      logic [20:0]          cp;
      logic [3:0]           used;
      logic                 joined;
      r  = DECODE_FAIL;
      hi = lead_value(lanes[31:0]);
      if (avail < jsue_pkg::AVAIL_ESCAPE || !hi[16]) return r;
      cp     = {5'b0, hi[15:0]};
      used   = jsue_pkg::CONSUMED_SINGLE;
      joined = 1'b0;
      if (hi[15:0] >= jsue_pkg::SURR_HI_FIRST && hi[15:0] <= jsue_pkg::SURR_HI_LAST) begin
         // A high half joins only with a full backslash-u and a low half in range.
         lo = lead_value(lanes[79:48]);
         if (avail >= jsue_pkg::AVAIL_PAIR && lanes[39:32] == jsue_pkg::CHAR_BACKSLASH
             && lanes[47:40] == jsue_pkg::CHAR_U && lo[16]
             && lo[15:0] >= jsue_pkg::SURR_LO_FIRST && lo[15:0] <= jsue_pkg::SURR_LO_LAST) begin
            cp     = jsue_pkg::SUPP_BASE + {1'b0, hi[9:0], lo[9:0]};
            used   = jsue_pkg::CONSUMED_PAIR;
            joined = 1'b1;
         end
         if (!joined) cp = jsue_pkg::REPLACEMENT;
      end else if (hi[15:0] >= jsue_pkg::SURR_LO_FIRST && hi[15:0] <= jsue_pkg::SURR_LO_LAST) begin
         cp = jsue_pkg::REPLACEMENT;
      end
      r.ok       = 1'b1;
      r.consumed = used;
      // UTF-8 encoding by code point range.
      if (cp < jsue_pkg::LIMIT_ONE) begin
         r.byte0      = cp[7:0];
         r.byte_count = jsue_pkg::COUNT_ONE;
      end else if (cp < jsue_pkg::LIMIT_TWO) begin
         r.byte0      = jsue_pkg::LEAD_TWO | {3'b0, cp[10:6]};
         r.byte1      = jsue_pkg::CONT_MARK | {2'b0, cp[5:0]};
         r.byte_count = jsue_pkg::COUNT_TWO;
      end else if (cp < jsue_pkg::LIMIT_THREE) begin
         r.byte0      = jsue_pkg::LEAD_THREE | {4'b0, cp[15:12]};
         r.byte1      = jsue_pkg::CONT_MARK | {2'b0, cp[11:6]};
         r.byte2      = jsue_pkg::CONT_MARK | {2'b0, cp[5:0]};
         r.byte_count = jsue_pkg::COUNT_THREE;
      end else begin
         r.byte0      = jsue_pkg::LEAD_FOUR | {5'b0, cp[20:18]};
         r.byte1      = jsue_pkg::CONT_MARK | {2'b0, cp[17:12]};
         r.byte2      = jsue_pkg::CONT_MARK | {2'b0, cp[11:6]};
         r.byte3      = jsue_pkg::CONT_MARK | {2'b0, cp[5:0]};
         r.byte_count = jsue_pkg::COUNT_FOUR;
      end
      return r;
   endfunction

   // Successful decode written out by hand for the directed table.
   function automatic jsue_pkg::result_type utf8_want(logic [3:0] cons, logic [2:0] cnt,
                                                      logic [7:0] b0, logic [7:0] b1,
                                                      logic [7:0] b2, logic [7:0] b3);
      jsue_pkg::result_type r;
      r.ok         = 1'b1;
      r.consumed   = cons;
      r.byte_count = cnt;
      r.byte0      = b0;
      r.byte1      = b1;
      r.byte2      = b2;
      r.byte3      = b3;
      return r;
   endfunction

   // Hex character for a nibble, letters in random case.
   function automatic logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return jsue_pkg::CHAR_ZERO + {4'b0, nib};
      return ($urandom_range(0, 1) ? jsue_pkg::CHAR_LOWER_A : jsue_pkg::CHAR_UPPER_A)
             + {4'b0, nib} - 8'd10;
   endfunction

   // Four hex characters for a 16-bit value, most significant digit in the low byte.
   function automatic logic [31:0] hex_group(logic [15:0] v);
      return {hex_char(v[3:0]), hex_char(v[7:4]), hex_char(v[11:8]), hex_char(v[15:12])};
   endfunction

   // Per-item wait, none during quiet phases.
   function automatic int draw_wait();
      return quiet_phase ? 0 : $urandom_range(0, 5);
   endfunction

   // Offer one escape and record its expected result when the transaction is accepted.
   // Called at a falling edge, returns at a falling edge.
   task automatic send_escape(logic [79:0] lanes, logic [3:0] avail,
                              jsue_pkg::result_type want);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, avail, lanes};
      do @(posedge clock); while (!req_tready);
      pending_utf8.push_back(want);
      @(negedge clock);
   endtask

   // Random escape: mostly well-formed singles and pairs, some broken pairs and noise.
   task automatic send_random_escape();
      logic [79:0] lanes;
      logic [3:0]  avail;
      logic [15:0] v;
      int          kind;
      kind = $urandom_range(0, 99);
      for (int k = 0; k < jsue_pkg::LaneCount; k++) lanes[8*k +: 8] = 8'($urandom_range(0, 255));
      avail = 4'($urandom_range(jsue_pkg::AVAIL_ESCAPE, 15));
      if (kind < 30) begin
         // Single escape spread over the one, two and three byte ranges.
         case ($urandom_range(0, 2))
            0:       v = 16'($urandom_range(0, 16'h007F));
            1:       v = 16'($urandom_range(16'h0080, 16'h07FF));
            default: v = 16'($urandom_range(0, 16'hFFFF));
         endcase
         lanes[31:0] = hex_group(v);
      end else if (kind < 65) begin
         // Surrogate pair, broken in one place now and then.
         avail = 4'($urandom_range(jsue_pkg::AVAIL_PAIR, 15));
         lanes = {hex_group(jsue_pkg::SURR_LO_FIRST | 16'($urandom_range(0, 1023))),
                  jsue_pkg::CHAR_U, jsue_pkg::CHAR_BACKSLASH,
                  hex_group(jsue_pkg::SURR_HI_FIRST | 16'($urandom_range(0, 1023)))};
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
               0:       avail = 4'($urandom_range(0, jsue_pkg::AVAIL_PAIR - 1));
               1:       lanes[79:48] = hex_group(16'($urandom_range(0, 16'hFFFF)));
               default: lanes[8*$urandom_range(0, 9) +: 8] = 8'($urandom_range(0, 255));
            endcase
         end
      end else if (kind < 75) begin
         // Lone surrogate of either kind.
         lanes[31:0] = hex_group(16'($urandom_range(jsue_pkg::SURR_HI_FIRST,
                                                    jsue_pkg::SURR_LO_LAST)));
      end else if (kind < 85) begin
         // Leading digits cut short by some other byte.
         lanes[31:0] = hex_group(16'($urandom_range(0, 16'hFFFF)));
         lanes[8*$urandom_range(1, 3) +: 8] = 8'($urandom_range(0, 255));
      end else begin
         // Raw noise with any count.
         avail = 4'($urandom_range(0, 15));
      end
      send_escape(lanes, avail, decode_escape(lanes, avail));
   endtask

   // Stimulus, end of run and verdict.
   initial begin
      logic [79:0] lanes;
      dir_table = '{
         '{"0000xxxxxx", 4'd4,  1'b1, utf8_want(4'd4, 3'd1, 8'h00, 8'h00, 8'h00, 8'h00)},
         '{"007Fxxxxxx", 4'd4,  1'b1, utf8_want(4'd4, 3'd1, 8'h7F, 8'h00, 8'h00, 8'h00)},
         '{"0080xxxxxx", 4'd5,  1'b0, DECODE_FAIL},
         '{"07ffxxxxxx", 4'd6,  1'b0, DECODE_FAIL},
         '{"0800xxxxxx", 4'd7,  1'b0, DECODE_FAIL},
         '{"FFFFxxxxxx", 4'd10, 1'b1, utf8_want(4'd4, 3'd3, 8'hEF, 8'hBF, 8'hBF, 8'h00)},
         '{"abcdxxxxxx", 4'd8,  1'b0, DECODE_FAIL},
         '{"ABCDxxxxxx", 4'd9,  1'b0, DECODE_FAIL},
         '{"12g4xxxxxx", 4'd4,  1'b0, DECODE_FAIL},
         '{"9/:@xxxxxx", 4'd4,  1'b0, DECODE_FAIL},
         '{"`aFGxxxxxx", 4'd10, 1'b1, DECODE_FAIL},
         '{"g123xxxxxx", 4'd10, 1'b1, DECODE_FAIL},
         '{"0041xxxxxx", 4'd3,  1'b1, DECODE_FAIL},
         '{"0041xxxxxx", 4'd0,  1'b1, DECODE_FAIL},
         '{"0041xxxxxx", 4'd15, 1'b0, DECODE_FAIL},
         '{"D83D\\uDE00", 4'd10, 1'b1, utf8_want(4'd10, 3'd4, 8'hF0, 8'h9F, 8'h98, 8'h80)},
         '{"DBFF\\uDFFF", 4'd10, 1'b1, utf8_want(4'd10, 3'd4, 8'hF4, 8'h8F, 8'hBF, 8'hBF)},
         '{"d800\\udc00", 4'd15, 1'b0, DECODE_FAIL},
         '{"D83D\\uDE00", 4'd9,  1'b1, utf8_want(4'd4, 3'd3, 8'hEF, 8'hBF, 8'hBD, 8'h00)},
         '{"D83D\\uD800", 4'd10, 1'b0, DECODE_FAIL},
         '{"D83D\\uzz00", 4'd10, 1'b0, DECODE_FAIL},
         '{"D83D/uDE00", 4'd10, 1'b0, DECODE_FAIL},
         '{"D83D\\UDE00", 4'd10, 1'b0, DECODE_FAIL},
         '{"D83D\\uDE.0", 4'd10, 1'b0, DECODE_FAIL},
         '{"DC00xxxxxx", 4'd4,  1'b1, utf8_want(4'd4, 3'd3, 8'hEF, 8'hBF, 8'hBD, 8'h00)},
         '{"DFFFxxxxxx", 4'd4,  1'b0, DECODE_FAIL}
      };

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table; rows without a typed result go through the decoder model.
      foreach (dir_table[i]) begin
         for (int k = 0; k < jsue_pkg::LaneCount; k++)
            lanes[8*k +: 8] = dir_table[i].text[79-8*k -: 8];
         send_escape(lanes, dir_table[i].avail,
                     dir_table[i].typed ? dir_table[i].want
                                        : decode_escape(lanes, dir_table[i].avail));
      end

      // Random part, with quiet stretches where neither side waits.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_phase <= (n % 150) >= 110;
         send_random_escape();
      end
      req_tvalid <= 1'b0;
      quiet_phase <= 1'b0;

      while (pending_utf8.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (bad_results == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Result side: stall a random number of cycles before each transaction.
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Compare each accepted result with the oldest expectation, field by field.
   always @(posedge clock) begin
      jsue_pkg::result_type got;
      jsue_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok         = rsp_tuser[0];
         got.consumed   = rsp_tdata[3:0];
         got.byte_count = rsp_tdata[6:4];
         got.byte0      = rsp_tdata[14:7];
         got.byte1      = rsp_tdata[22:15];
         got.byte2      = rsp_tdata[30:23];
         got.byte3      = rsp_tdata[38:31];
         if (pending_utf8.size() == 0) begin
            if (bad_results < REPORT_MAX)
               $display("unexpected result transaction: ok=%0b consumed=%0d count=%0d",
                        got.ok, got.consumed, got.byte_count);
            bad_results++;
         end else begin
            want = pending_utf8.pop_front();
            if (got.ok !== want.ok || got.consumed !== want.consumed
                || got.byte_count !== want.byte_count || got.byte0 !== want.byte0
                || got.byte1 !== want.byte1 || got.byte2 !== want.byte2
                || got.byte3 !== want.byte3) begin
               if (bad_results < REPORT_MAX)
                  $display("mismatch: expected ok=%0b consumed=%0d count=%0d bytes=%h %h %h %h, ",
                           want.ok, want.consumed, want.byte_count,
                           want.byte0, want.byte1, want.byte2, want.byte3,
                           "got ok=%0b consumed=%0d count=%0d bytes=%h %h %h %h",
                           got.ok, got.consumed, got.byte_count,
                           got.byte0, got.byte1, got.byte2, got.byte3);
               bad_results++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule

FILE: sim.f
design/jsue_pkg.sv
design/jsue_char_lane.sv
design/jsue_merge.sv
design/json_unicode_escape_to_utf8_top.sv
dv/tb_json_unicode_escape_to_utf8_top.sv
